### hdl/atcg_pkg.sv
// Text console grid: shared types, constants and the colour palette.
// Used by every module of the console grid core; depends on nothing.
package atcg_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int ADDR_W      = COL_W + ROW_W;
  localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
  localparam int NC_W        = COL_W + 1;
  localparam int LIM_W       = ROW_W + 1;

  localparam logic [23:0] RESET_FG = 24'hAAAAAA;
  localparam logic [23:0] RESET_BG = 24'h000000;

  localparam logic [2:0] CFG_COLUMNS    = 3'd0;
  localparam logic [2:0] CFG_TOTAL_ROWS = 3'd1;
  localparam logic [2:0] CFG_USABLE     = 3'd2;
  localparam logic [2:0] CFG_DEFAULT_FG = 3'd3;
  localparam logic [2:0] CFG_DEFAULT_BG = 3'd4;

  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_8      = 8'h38;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] FINAL_LO  = 8'h40;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UB     = 8'h42;
  localparam logic [7:0] CH_UC     = 8'h43;
  localparam logic [7:0] CH_UD     = 8'h44;
  localparam logic [7:0] CH_UE     = 8'h45;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UG     = 8'h47;
  localparam logic [7:0] CH_UH     = 8'h48;
  localparam logic [7:0] CH_UJ     = 8'h4A;
  localparam logic [7:0] CH_UK     = 8'h4B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LC     = 8'h63;
  localparam logic [7:0] CH_LD     = 8'h64;
  localparam logic [7:0] CH_LF_F   = 8'h66;
  localparam logic [7:0] CH_LM     = 8'h6D;
  localparam logic [7:0] CH_LS     = 8'h73;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] FINAL_HI  = 8'h7E;

  typedef enum logic [2:0] {
    P_GROUND, P_ESC, P_CSI, P_OSC, P_SWALLOW, P_OSC_ESC
  } parse_t;

  typedef enum logic [3:0] {
    C_CLEAR, C_CLEAR_WAIT, C_IDLE, C_RDATA, C_EXEC, C_WAIT_PRE, C_ACT, C_WAIT,
    C_SGR, C_FIN
  } ctrl_state_t;

  typedef enum logic [1:0] {W_IDLE, W_COPY, W_DRAIN, W_FILL} walk_state_t;

  typedef enum logic {WM_FILL, WM_SCROLL} walk_mode_t;

  typedef struct packed {
    logic       command;
    logic [7:0] in_byte;
    logic [6:0] read_column;
    logic [5:0] read_row;
  } item_t;

  typedef struct packed {
    logic        cell_written;
    logic [6:0]  written_column;
    logic [5:0]  written_row;
    logic        needs_repaint;
    logic [7:0]  cell_char;
    logic [23:0] cell_foreground;
    logic [23:0] cell_background;
  } result_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic [23:0] fg;
    logic [23:0] bg;
  } cell_t;

  typedef struct packed {
    logic [NC_W-1:0]  cols;
    logic [LIM_W-1:0] total;
    logic [LIM_W-1:0] lim;
  } geom_t;

  typedef struct packed {
    logic             start;
    walk_mode_t       mode;
    logic [ROW_W-1:0] r0;
    logic [COL_W-1:0] c0;
    logic [ROW_W-1:0] r1;
    logic [COL_W-1:0] c1;
    logic [LIM_W-1:0] lim;
    logic [NC_W-1:0]  nc;
    logic [23:0]      fg;
    logic [23:0]      bg;
  } walk_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    cell_t             data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  function automatic logic [23:0] palette(input logic [3:0] idx);
    logic [23:0] c;
    unique case (idx)
      4'd0:  c = 24'h000000;
      4'd1:  c = 24'hAA0000;
      4'd2:  c = 24'h00AA00;
      4'd3:  c = 24'hAA5500;
      4'd4:  c = 24'h0000AA;
      4'd5:  c = 24'hAA00AA;
      4'd6:  c = 24'h00AAAA;
      4'd7:  c = 24'hAAAAAA;
      4'd8:  c = 24'h555555;
      4'd9:  c = 24'hFF5555;
      4'd10: c = 24'h55FF55;
      4'd11: c = 24'hFFFF55;
      4'd12: c = 24'h5555FF;
      4'd13: c = 24'hFF55FF;
      4'd14: c = 24'h55FFFF;
      4'd15: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

endpackage

### hdl/atcg_cell_mem.sv
// Cell store: one write port and one registered read port.
// Depends on atcg_pkg for the cell and port types.
module atcg_cell_mem (
  input  logic             clk,
  input  atcg_pkg::mem_wr_t wr,
  input  atcg_pkg::mem_rd_t rd,
  output atcg_pkg::cell_t   rdata
);
  import atcg_pkg::*;

  cell_t mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

### hdl/atcg_walker.sv
// Cell store walker: region fill and scroll-up copy, one cell per cycle.
// Depends on atcg_pkg; drives the cell store while busy.
module atcg_walker (
  input  logic                clk,
  input  logic                rst,
  input  atcg_pkg::walk_req_t req,
  input  atcg_pkg::cell_t     rdata,
  output logic                busy,
  output atcg_pkg::mem_wr_t   wr,
  output atcg_pkg::mem_rd_t   rd
);
  import atcg_pkg::*;

  walk_state_t      wst, wst_next;
  logic [ROW_W-1:0] r, r_next, r1, r1_next;
  logic [COL_W-1:0] c, c_next, c1, c1_next;
  logic [LIM_W-1:0] lim, lim_next;
  logic [NC_W-1:0]  nc, nc_next;
  logic [23:0]      fg, fg_next, bg, bg_next;
  logic             pend, pend_next;
  logic [ADDR_W-1:0] paddr, paddr_next;

  logic [COL_W-1:0] nc_m1, ce;
  logic [LIM_W-1:0] lim_m1, lim_m2, r_inc;
  logic             fill_en, last_in_row, last_row;

  assign nc_m1       = COL_W'(nc - 1'b1);
  assign lim_m1      = lim - 1'b1;
  assign lim_m2      = lim - 2'd2;
  assign r_inc       = {1'b0, r} + 1'b1;
  assign ce          = (r == r1) ? c1 : nc_m1;
  assign fill_en     = (wst == W_FILL) && ({1'b0, r} < lim) && (c <= ce) &&
                       ({1'b0, c} < nc);
  assign last_in_row = (c >= ce) || (c >= nc_m1);
  assign last_row    = (r >= r1) || (r_inc >= lim);
  assign busy        = (wst != W_IDLE);

  always_comb begin
    wst_next = wst;
    unique case (wst)
      W_IDLE: begin
        if (req.start) begin
          wst_next = (req.mode == WM_SCROLL && req.lim > 1) ? W_COPY : W_FILL;
        end
      end
      W_COPY: begin
        if (c == nc_m1 && r == lim_m2[ROW_W-1:0]) begin
          wst_next = W_DRAIN;
        end
      end
      W_DRAIN: wst_next = W_FILL;
      W_FILL: begin
        if (last_in_row && last_row) begin
          wst_next = W_IDLE;
        end
      end
      default: wst_next = W_IDLE;
    endcase
  end

  always_comb begin
    r_next     = r;
    c_next     = c;
    r1_next    = r1;
    c1_next    = c1;
    lim_next   = lim;
    nc_next    = nc;
    fg_next    = fg;
    bg_next    = bg;
    pend_next  = 1'b0;
    paddr_next = paddr;
    rd         = '0;
    wr.en      = pend | fill_en;
    wr.addr    = pend ? paddr : {r, c};
    wr.data    = pend ? rdata : cell_t'{ch: CH_SPACE, fg: fg, bg: bg};
    unique case (wst)
      W_IDLE: begin
        if (req.start) begin
          lim_next = req.lim;
          nc_next  = req.nc;
          fg_next  = req.fg;
          bg_next  = req.bg;
          if (req.mode == WM_SCROLL) begin
            r_next  = req.lim > 1 ? '0 : ROW_W'(req.lim - 1'b1);
            c_next  = '0;
            r1_next = ROW_W'(req.lim - 1'b1);
            c1_next = COL_W'(req.nc - 1'b1);
          end else begin
            r_next  = req.r0;
            c_next  = req.c0;
            r1_next = req.r1;
            c1_next = req.c1;
          end
        end
      end
      W_COPY: begin
        rd.en      = 1'b1;
        rd.addr    = {ROW_W'(r_inc), c};
        pend_next  = 1'b1;
        paddr_next = {r, c};
        if (c == nc_m1) begin
          c_next = '0;
          if (r != lim_m2[ROW_W-1:0]) begin
            r_next = r + 1'b1;
          end
        end else begin
          c_next = c + 1'b1;
        end
      end
      W_DRAIN: begin
        r_next = lim_m1[ROW_W-1:0];
        c_next = '0;
      end
      W_FILL: begin
        if (last_in_row) begin
          r_next = r + 1'b1;
          c_next = '0;
        end else begin
          c_next = c + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wst  <= W_IDLE;
      pend <= 1'b0;
    end else begin
      wst  <= wst_next;
      pend <= pend_next;
    end
    r     <= r_next;
    c     <= c_next;
    r1    <= r1_next;
    c1    <= c1_next;
    lim   <= lim_next;
    nc    <= nc_next;
    fg    <= fg_next;
    bg    <= bg_next;
    paddr <= paddr_next;
  end

endmodule

### hdl/atcg_ctrl.sv
// Console control: byte parser, cursor and colour state, command sequencer.
// Depends on atcg_pkg; requests walks and drives single-cell accesses.
module atcg_ctrl #(
  parameter int PARAM_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  atcg_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_ready,
  output atcg_pkg::result_t   result,
  input  atcg_pkg::geom_t     geom,
  input  logic [23:0]         dfg,
  input  logic [23:0]         dbg,
  input  logic                walk_busy,
  output atcg_pkg::walk_req_t walk_req,
  output atcg_pkg::mem_wr_t   mem_wr,
  output atcg_pkg::mem_rd_t   mem_rd,
  input  atcg_pkg::cell_t     mem_rdata
);
  import atcg_pkg::*;

  localparam int PC_W = $clog2(PARAM_SLOTS + 1);
  localparam int IX_W = $clog2(PARAM_SLOTS);
  localparam logic [PC_W-1:0] SLOTS_PC = PC_W'(PARAM_SLOTS);

  ctrl_state_t      state, state_next;
  parse_t           pst, pst_next;
  logic [COL_W-1:0] cc, cc_next, sc, sc_next;
  logic [ROW_W-1:0] cr, cr_next, sr, sr_next;
  logic [23:0]      fg, fg_next, bg, bg_next;
  logic [PC_W-1:0]  pcount, pcount_next;
  logic [15:0]      params [PARAM_SLOTS];
  logic [15:0]      params_next [PARAM_SLOTS];
  logic [IX_W-1:0]  sidx, sidx_next;
  item_t            item_q, item_q_next;
  result_t          res, res_next, out, out_next;
  logic             out_valid, out_valid_next;

  logic             accept, slot_free;
  logic [7:0]       b;
  logic [NC_W-1:0]  nc;
  logic [LIM_W-1:0] lim, lim_m1;
  logic [COL_W-1:0] nc_m1;
  logic             wrap_pre, scroll_pre, wrap_post, row_adv, scroll_post;
  logic [LIM_W-1:0] row_pre, row_inc;
  logic [NC_W-1:0]  col_inc;
  logic             is_digit, is_final, is_glyph;
  logic [PC_W-1:0]  pc_m1, pc_semi;
  logic [IX_W-1:0]  didx, pidx;
  logic [15:0]      pval, n, n2, nm1, n2m1, pm30, pm40, pm82, pm92;
  logic [16:0]      sum_r, sum_c;
  logic             is_ed, is_el;

  assign b        = item_q.in_byte;
  assign nc       = geom.cols;
  assign lim      = geom.lim;
  assign lim_m1   = lim - 1'b1;
  assign nc_m1    = COL_W'(nc - 1'b1);
  assign accept   = item_valid && item_ready;
  assign slot_free = !out_valid || result_ready;

  assign wrap_pre   = ({1'b0, cc} >= nc);
  assign row_pre    = {1'b0, cr} + LIM_W'(wrap_pre);
  assign scroll_pre = (row_pre >= lim);
  assign is_glyph   = (b != CH_LF) && (b != CH_CR) && (b != CH_BS);
  assign col_inc    = {1'b0, cc} + 1'b1;
  assign wrap_post  = (col_inc >= nc);
  assign row_inc    = {1'b0, cr} + 1'b1;
  assign row_adv    = (b == CH_LF) || (is_glyph && wrap_post);
  assign scroll_post = row_adv && (row_inc >= lim);

  assign is_digit = (b >= CH_0) && (b <= CH_9);
  assign is_final = (b >= FINAL_LO) && (b <= FINAL_HI);
  assign is_ed    = (b == CH_UJ);
  assign is_el    = (b == CH_UK);
  assign pc_m1    = pcount - 1'b1;
  assign pc_semi  = (pcount == '0) ? PC_W'(1) : pcount;
  assign didx     = (pcount == '0) ? '0 : pc_m1[IX_W-1:0];
  assign pidx     = (state == C_SGR) ? sidx : didx;
  assign pval     = params[pidx];
  assign n        = (pcount != '0 && params[0] != '0) ? params[0] : 16'd1;
  assign n2       = (pcount > PC_W'(1) && params[1] != '0) ? params[1] : 16'd1;
  assign nm1      = n - 1'b1;
  assign n2m1     = n2 - 1'b1;
  assign sum_r    = {11'b0, cr} + {1'b0, n};
  assign sum_c    = {10'b0, cc} + {1'b0, n};
  assign pm30     = pval - 16'd30;
  assign pm40     = pval - 16'd40;
  assign pm82     = pval - 16'd82;
  assign pm92     = pval - 16'd92;

  assign item_ready   = (state == C_IDLE);
  assign result_valid = out_valid;
  assign result       = out;

  always_comb begin
    state_next = state;
    unique case (state)
      C_CLEAR:      state_next = C_CLEAR_WAIT;
      C_CLEAR_WAIT: if (!walk_busy) state_next = C_IDLE;
      C_IDLE: begin
        if (accept) begin
          state_next = item.command ? C_RDATA : C_EXEC;
        end
      end
      C_RDATA: state_next = C_FIN;
      C_EXEC: begin
        state_next = C_FIN;
        unique case (pst)
          P_GROUND: begin
            if (b != CH_ESC) begin
              state_next = scroll_pre ? C_WAIT_PRE : C_ACT;
            end
          end
          P_ESC: if (b == CH_LC) state_next = C_WAIT;
          P_CSI: begin
            if (is_final && (is_ed || is_el)) begin
              state_next = C_WAIT;
            end else if (is_final && b == CH_LM && pcount != '0) begin
              state_next = C_SGR;
            end
          end
          default: ;
        endcase
      end
      C_WAIT_PRE: if (!walk_busy) state_next = C_ACT;
      C_ACT:      state_next = scroll_post ? C_WAIT : C_FIN;
      C_WAIT:     if (!walk_busy) state_next = C_FIN;
      C_SGR:      if (sidx == pc_m1[IX_W-1:0]) state_next = C_FIN;
      C_FIN:      if (slot_free) state_next = C_IDLE;
      default:    state_next = C_IDLE;
    endcase
  end

  always_comb begin
    pst_next       = pst;
    cc_next        = cc;
    cr_next        = cr;
    sc_next        = sc;
    sr_next        = sr;
    fg_next        = fg;
    bg_next        = bg;
    pcount_next    = pcount;
    params_next    = params;
    sidx_next      = sidx;
    item_q_next    = item_q;
    res_next       = res;
    out_next       = out;
    out_valid_next = out_valid && !result_ready;
    walk_req       = '0;
    mem_wr         = '0;
    mem_rd         = '0;
    unique case (state)
      C_CLEAR: begin
        walk_req.start = 1'b1;
        walk_req.mode  = WM_FILL;
        walk_req.r1    = ROW_W'(MAX_ROWS - 1);
        walk_req.c1    = COL_W'(MAX_COLUMNS - 1);
        walk_req.lim   = LIM_W'(MAX_ROWS);
        walk_req.nc    = NC_W'(MAX_COLUMNS);
        walk_req.fg    = RESET_FG;
        walk_req.bg    = RESET_BG;
      end
      C_IDLE: begin
        if (accept) begin
          item_q_next = item;
          res_next    = '0;
          if (item.command) begin
            mem_rd.en   = 1'b1;
            mem_rd.addr = {item.read_row, item.read_column};
          end
        end
      end
      C_RDATA: begin
        if ({1'b0, item_q.read_column} < nc && {1'b0, item_q.read_row} < geom.total) begin
          res_next.cell_char       = mem_rdata.ch;
          res_next.cell_foreground = mem_rdata.fg;
          res_next.cell_background = mem_rdata.bg;
        end
      end
      C_EXEC: begin
        unique case (pst)
          P_GROUND: begin
            if (b == CH_ESC) begin
              pst_next = P_ESC;
            end else begin
              if (wrap_pre) cc_next = '0;
              if (scroll_pre) begin
                walk_req.start = 1'b1;
                walk_req.mode  = WM_SCROLL;
                walk_req.lim   = lim;
                walk_req.nc    = nc;
                walk_req.fg    = fg;
                walk_req.bg    = bg;
                cr_next        = lim_m1[ROW_W-1:0];
                res_next.needs_repaint = 1'b1;
                if (lim <= LIM_W'(1)) cc_next = '0;
              end else begin
                cr_next = row_pre[ROW_W-1:0];
              end
            end
          end
          P_ESC: begin
            pst_next = P_GROUND;
            if (b == CH_LBRACK) begin
              pst_next    = P_CSI;
              pcount_next = '0;
              for (int i = 0; i < PARAM_SLOTS; i++) params_next[i] = '0;
            end else if (b == CH_RBRACK) begin
              pst_next = P_OSC;
            end else if (b == CH_7) begin
              sc_next = cc;
              sr_next = cr;
            end else if (b == CH_8) begin
              sc_next = sc;
              cc_next = ({1'b0, sc} >= nc) ? nc_m1 : sc;
              cr_next = ({1'b0, sr} >= lim) ? lim_m1[ROW_W-1:0] : sr;
            end else if (b == CH_LC) begin
              fg_next = dfg;
              bg_next = dbg;
              cc_next = '0;
              cr_next = '0;
              walk_req.start = 1'b1;
              walk_req.mode  = WM_FILL;
              walk_req.r1    = lim_m1[ROW_W-1:0];
              walk_req.c1    = nc_m1;
              walk_req.lim   = lim;
              walk_req.nc    = nc;
              walk_req.fg    = dfg;
              walk_req.bg    = dbg;
              res_next.needs_repaint = 1'b1;
            end else if (b == CH_LPAREN || b == CH_RPAREN || b == CH_STAR ||
                         b == CH_PLUS) begin
              pst_next = P_SWALLOW;
            end
          end
          P_CSI: begin
            if (is_digit) begin
              params_next[didx] = (params[didx] << 3) + (params[didx] << 1) +
                                  {12'b0, b[3:0]};
              if (pcount == '0) pcount_next = PC_W'(1);
            end else if (b == CH_SEMI) begin
              pcount_next = (pc_semi < SLOTS_PC) ? pc_semi + 1'b1 : pc_semi;
            end else if (is_final) begin
              pst_next = P_GROUND;
              sidx_next = '0;
              unique case (b)
                CH_UA, CH_UF: begin
                  cr_next = ({10'b0, cr} > n) ? cr - n[ROW_W-1:0] : '0;
                  if (b == CH_UF) cc_next = '0;
                end
                CH_UB, CH_UE: begin
                  cr_next = (sum_r >= {10'b0, lim}) ? lim_m1[ROW_W-1:0] :
                            sum_r[ROW_W-1:0];
                  if (b == CH_UE) cc_next = '0;
                end
                CH_UC: begin
                  cc_next = (sum_c >= {9'b0, nc}) ? nc_m1 : sum_c[COL_W-1:0];
                end
                CH_UD: begin
                  cc_next = ({9'b0, cc} > n) ? cc - n[COL_W-1:0] : '0;
                end
                CH_UG, CH_BTICK: begin
                  cc_next = (nm1 >= {8'b0, nc}) ? nc_m1 : nm1[COL_W-1:0];
                end
                CH_LD: begin
                  cr_next = (nm1 >= {9'b0, lim}) ? lim_m1[ROW_W-1:0] : nm1[ROW_W-1:0];
                end
                CH_UH, CH_LF_F: begin
                  cr_next = (nm1 >= {9'b0, lim}) ? lim_m1[ROW_W-1:0] : nm1[ROW_W-1:0];
                  cc_next = (n2m1 >= {8'b0, nc}) ? nc_m1 : n2m1[COL_W-1:0];
                end
                CH_UJ, CH_UK: begin
                  walk_req.start = 1'b1;
                  walk_req.mode  = WM_FILL;
                  walk_req.lim   = lim;
                  walk_req.nc    = nc;
                  walk_req.fg    = fg;
                  walk_req.bg    = bg;
                  res_next.needs_repaint = 1'b1;
                  if (pcount == '0 || params[0] == 16'd0) begin
                    walk_req.r0 = cr;
                    walk_req.c0 = cc;
                    walk_req.r1 = is_ed ? lim_m1[ROW_W-1:0] : cr;
                    walk_req.c1 = nc_m1;
                  end else if (params[0] == 16'd1) begin
                    walk_req.r0 = is_ed ? '0 : cr;
                    walk_req.c0 = '0;
                    walk_req.r1 = cr;
                    walk_req.c1 = cc;
                  end else begin
                    walk_req.r0 = is_ed ? '0 : cr;
                    walk_req.c0 = '0;
                    walk_req.r1 = is_ed ? lim_m1[ROW_W-1:0] : cr;
                    walk_req.c1 = nc_m1;
                  end
                end
                CH_LM: begin
                  if (pcount == '0) begin
                    fg_next = dfg;
                    bg_next = dbg;
                  end
                end
                CH_LS: begin
                  sc_next = cc;
                  sr_next = cr;
                end
                CH_LU: begin
                  cc_next = ({1'b0, sc} >= nc) ? nc_m1 : sc;
                  cr_next = ({1'b0, sr} >= lim) ? lim_m1[ROW_W-1:0] : sr;
                end
                default: ;
              endcase
            end
          end
          P_OSC: begin
            if (b == CH_BEL) begin
              pst_next = P_GROUND;
            end else if (b == CH_ESC) begin
              pst_next = P_OSC_ESC;
            end
          end
          default: pst_next = P_GROUND;
        endcase
      end
      C_ACT: begin
        mem_wr.addr    = {cr, cc};
        mem_wr.data.fg = fg;
        mem_wr.data.bg = bg;
        mem_wr.data.ch = b;
        if (b == CH_BS) begin
          mem_wr.en      = 1'b1;
          mem_wr.data.ch = CH_SPACE;
          mem_wr.addr    = {cr, (cc != '0) ? cc - 1'b1 : cc};
          cc_next        = (cc != '0) ? cc - 1'b1 : cc;
          res_next.cell_written   = 1'b1;
          res_next.written_column = (cc != '0) ? cc - 1'b1 : cc;
          res_next.written_row    = cr;
        end else if (b == CH_CR) begin
          cc_next = '0;
        end else if (b == CH_LF) begin
          cc_next = '0;
        end else begin
          mem_wr.en = 1'b1;
          res_next.cell_written   = 1'b1;
          res_next.written_column = cc;
          res_next.written_row    = cr;
          cc_next = wrap_post ? '0 : col_inc[COL_W-1:0];
        end
        if (row_adv) begin
          if (scroll_post) begin
            walk_req.start = 1'b1;
            walk_req.mode  = WM_SCROLL;
            walk_req.lim   = lim;
            walk_req.nc    = nc;
            walk_req.fg    = fg;
            walk_req.bg    = bg;
            cr_next        = lim_m1[ROW_W-1:0];
            res_next.needs_repaint = 1'b1;
          end else begin
            cr_next = row_inc[ROW_W-1:0];
          end
        end
      end
      C_SGR: begin
        sidx_next = sidx + 1'b1;
        if (pval == 16'd0) begin
          fg_next = dfg;
          bg_next = dbg;
        end else if (pval >= 16'd30 && pval <= 16'd37) begin
          fg_next = palette(pm30[3:0]);
        end else if (pval == 16'd39) begin
          fg_next = dfg;
        end else if (pval >= 16'd40 && pval <= 16'd47) begin
          bg_next = palette(pm40[3:0]);
        end else if (pval == 16'd49) begin
          bg_next = dbg;
        end else if (pval >= 16'd90 && pval <= 16'd97) begin
          fg_next = palette(pm82[3:0]);
        end else if (pval >= 16'd100 && pval <= 16'd107) begin
          bg_next = palette(pm92[3:0]);
        end
      end
      C_FIN: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_next       = res;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_CLEAR;
      pst       <= P_GROUND;
      cc        <= '0;
      cr        <= '0;
      sc        <= '0;
      sr        <= '0;
      fg        <= RESET_FG;
      bg        <= RESET_BG;
      pcount    <= '0;
      sidx      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < PARAM_SLOTS; i++) params[i] <= '0;
    end else begin
      state     <= state_next;
      pst       <= pst_next;
      cc        <= cc_next;
      cr        <= cr_next;
      sc        <= sc_next;
      sr        <= sr_next;
      fg        <= fg_next;
      bg        <= bg_next;
      pcount    <= pcount_next;
      sidx      <= sidx_next;
      out_valid <= out_valid_next;
      params    <= params_next;
    end
    item_q <= item_q_next;
    res    <= res_next;
    out    <= out_next;
  end

endmodule

### hdl/ansi_text_console_grid_core.sv
// Text console grid core: configuration registers, store port arbitration.
// Depends on atcg_pkg, atcg_cell_mem, atcg_walker and atcg_ctrl.
//
// channel   direction  handshake                 payload
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
// item      in         item_valid / item_ready   item (item_t)
// result    out        result_valid / result_ready  result (result_t)
//
// SGR applies its parameters one after another. Scrolls, erases and full reset
// walk the cell store one cell per cycle. item_ready stays low after reset while
// all 8192 cells are cleared; configuration writes are taken throughout. A stalled
// result holds in the output register while the next item is already accepted.
module ansi_text_console_grid_core #(
  parameter int PARAM_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_data,
  input  logic              item_valid,
  output logic              item_ready,
  input  atcg_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output atcg_pkg::result_t result
);
  import atcg_pkg::*;

  logic [7:0]  columns;
  logic [6:0]  total_rows, text_rows;
  logic [23:0] default_foreground, default_background;

  geom_t     geom;
  walk_req_t walk_req;
  mem_wr_t   ctrl_wr, walk_wr, mem_wr;
  mem_rd_t   ctrl_rd, walk_rd, mem_rd;
  cell_t     mem_rdata;
  logic      walk_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns            <= 8'd80;
      total_rows         <= 7'd25;
      text_rows          <= 7'd0;
      default_foreground <= RESET_FG;
      default_background <= RESET_BG;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COLUMNS:    columns            <= cfg_data[7:0];
        CFG_TOTAL_ROWS: total_rows         <= cfg_data[6:0];
        CFG_USABLE:     text_rows          <= cfg_data[6:0];
        CFG_DEFAULT_FG: default_foreground <= cfg_data;
        CFG_DEFAULT_BG: default_background <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.cols = (columns == '0) ? NC_W'(1) :
                (columns > 8'(MAX_COLUMNS)) ? NC_W'(MAX_COLUMNS) : NC_W'(columns);
    geom.total = (total_rows == '0) ? LIM_W'(1) :
                 (total_rows > 7'(MAX_ROWS)) ? LIM_W'(MAX_ROWS) : LIM_W'(total_rows);
    geom.lim = (text_rows == '0 || LIM_W'(text_rows) > geom.total) ? geom.total :
               LIM_W'(text_rows);
  end

  assign mem_wr = walk_wr.en ? walk_wr : ctrl_wr;
  assign mem_rd = walk_rd.en ? walk_rd : ctrl_rd;

  atcg_cell_mem u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .rd    (mem_rd),
    .rdata (mem_rdata)
  );

  atcg_walker u_walker (
    .clk   (clk),
    .rst   (rst),
    .req   (walk_req),
    .rdata (mem_rdata),
    .busy  (walk_busy),
    .wr    (walk_wr),
    .rd    (walk_rd)
  );

  atcg_ctrl #(
    .PARAM_SLOTS (PARAM_SLOTS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .geom         (geom),
    .dfg          (default_foreground),
    .dbg          (default_background),
    .walk_busy    (walk_busy),
    .walk_req     (walk_req),
    .mem_wr       (ctrl_wr),
    .mem_rd       (ctrl_rd),
    .mem_rdata    (mem_rdata)
  );

endmodule
